### rtl/assert_macros.svh
// Assertion macros for the meter RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checks off while rst is high.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checks off while rst is high.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### rtl/dcbphm_pkg.sv
// Widths, register indexes and reset values for the DC blocker and peak meter.
// No dependencies.
package dcbphm_pkg;

  localparam int ADC_W    = 10;
  localparam int LEVEL_W  = 16;
  localparam int MAG_W    = 15;
  localparam int THR_W    = 15;
  localparam int HOLD_W   = 16;
  localparam int INTEG_W  = 25;
  localparam int DIFF_W   = INTEG_W + 1;
  localparam int LVL_W    = DIFF_W - 8;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_THR  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_HOLD = 8'd3;

  localparam logic [THR_W-1:0]  PEAK_THR_RST  = 15'd32000;
  localparam logic [HOLD_W-1:0] PEAK_HOLD_RST = 16'd385;
  localparam logic [THR_W-1:0]  NOM_THR_RST   = 15'd128;
  localparam logic [HOLD_W-1:0] NOM_HOLD_RST  = 16'd1924;

  typedef struct packed {
    logic [THR_W-1:0]  peak_thr;
    logic [HOLD_W-1:0] peak_hold;
    logic [THR_W-1:0]  nom_thr;
    logic [HOLD_W-1:0] nom_hold;
  } meter_cfg_t;

endpackage

### rtl/dc_block_peak_hold_meter.sv
// DC blocking high-pass filter with peak and nominal hold lamps.
// Depends on dcbphm_pkg and assert_macros.svh.
//
//   channel  dir  handshake                    payload
//   s_*      in   s_tvalid / s_tready          s_tdata: adc_sample
//   m_*      out  m_tvalid / m_tready          m_tdata: level, peak, nominal
//   cfg_*    in   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; a word passes
// the input register s0 and then the output register. The filter state and both
// hold counters update together on each advance, closing the integrator feedback loop.
// rst (synchronous) clears the stages, the state and restores register defaults.
// A stalled output holds its word; an empty input register takes one more word,
// then s_tready stays low until the output moves.
`include "assert_macros.svh"

module dc_block_peak_hold_meter #(
  parameter int HPF_SHIFT = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [9:0] adc_sample, [15:10] zero
  input  logic [dcbphm_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [15:0] filtered_level, [16] peak_lamp, [17] nominal_lamp, [23:18] zero
  output logic [dcbphm_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcbphm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcbphm_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import dcbphm_pkg::*;

  localparam logic [DIFF_W-1:0] SHIFT_RND = DIFF_W'((64'd1 << HPF_SHIFT) - 64'd1);
  localparam logic [DIFF_W-1:0] LVL_RND   = DIFF_W'(255);

  meter_cfg_t cfg;

  logic              s0_valid;
  logic [ADC_W-1:0]  s0_sample;
  logic              adv;

  logic signed [INTEG_W-1:0] integrator;
  logic signed [INTEG_W-1:0] integrator_next;
  logic [HOLD_W-1:0]         peak_count;
  logic [HOLD_W-1:0]         peak_count_next;
  logic [HOLD_W-1:0]         nominal_count;
  logic [HOLD_W-1:0]         nominal_count_next;

  logic signed [LEVEL_W-1:0] x16;
  logic signed [DIFF_W-1:0]  x;
  logic signed [DIFF_W-1:0]  y;
  logic signed [DIFF_W-1:0]  delta;
  logic signed [DIFF_W-1:0]  lvl_full;
  logic signed [LVL_W-1:0]   lvl;
  logic signed [LEVEL_W-1:0] level;
  logic [MAG_W-1:0]          mag;
  logic                      peak_hit;
  logic                      nom_hit;

  assign cfg_ready = 1'b1;
  assign adv       = s0_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s0_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_thr  <= PEAK_THR_RST;
      cfg.peak_hold <= PEAK_HOLD_RST;
      cfg.nom_thr   <= NOM_THR_RST;
      cfg.nom_hold  <= NOM_HOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PEAK_THR:  cfg.peak_thr  <= cfg_data[THR_W-1:0];
        REG_PEAK_HOLD: cfg.peak_hold <= cfg_data[HOLD_W-1:0];
        REG_NOM_THR:   cfg.nom_thr   <= cfg_data[THR_W-1:0];
        REG_NOM_HOLD:  cfg.nom_hold  <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Center the code: sample*64 - 32768 is the sample with its MSB inverted.
    x16   = {~s0_sample[ADC_W-1], s0_sample[ADC_W-2:0], 6'b0};
    x     = {{(DIFF_W-LEVEL_W-8){x16[LEVEL_W-1]}}, x16, 8'b0};
    y     = x - DIFF_W'(integrator);
    // Round toward zero on both arithmetic shifts.
    delta = $signed(y + (y[DIFF_W-1] ? SHIFT_RND : '0)) >>> HPF_SHIFT;
    integrator_next = integrator + delta[INTEG_W-1:0];
    lvl_full = $signed(y + (y[DIFF_W-1] ? LVL_RND : '0)) >>> 8;
    lvl      = lvl_full[LVL_W-1:0];

    if (!lvl[LVL_W-1] && (lvl[LVL_W-2:LEVEL_W-1] != '0)) begin
      level = 16'sh7FFF;
    end else if (lvl[LVL_W-1] && (lvl[LVL_W-2:LEVEL_W-1] != '1)) begin
      level = -16'sh8000;
    end else begin
      level = lvl[LEVEL_W-1:0];
    end

    if (level == -16'sh8000) begin
      mag = '1;
    end else if (level[LEVEL_W-1]) begin
      mag = MAG_W'(-level);
    end else begin
      mag = level[MAG_W-1:0];
    end

    peak_hit = mag >= cfg.peak_thr;
    nom_hit  = mag >= cfg.nom_thr;

    if (peak_hit) begin
      peak_count_next = cfg.peak_hold;
    end else if (peak_count != '0) begin
      peak_count_next = peak_count - 1'b1;
    end else begin
      peak_count_next = '0;
    end

    if (nom_hit) begin
      nominal_count_next = cfg.nom_hold;
    end else if (nominal_count != '0) begin
      nominal_count_next = nominal_count - 1'b1;
    end else begin
      nominal_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      integrator    <= '0;
      peak_count    <= '0;
      nominal_count <= '0;
    end else begin
      if (s_tready) begin
        s0_valid <= s_tvalid;
      end
      if (adv) begin
        m_tvalid      <= 1'b1;
        integrator    <= integrator_next;
        peak_count    <= peak_count_next;
        nominal_count <= nominal_count_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers: load the input word on accept, the result on advance.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s0_sample <= s_tdata[ADC_W-1:0];
    end
    if (adv) begin
      m_tdata <= {6'b0, (nominal_count_next != '0), (peak_count_next != '0), level};
    end
  end

  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !s0_valid && !m_tvalid)
  `ASSERT_NEXT(a_s0_hold, clk, rst, s0_valid && !adv, s0_valid && $stable(s0_sample))
  `ASSERT_NEXT(a_state_hold, clk, rst, !adv,
               $stable(integrator) && $stable(peak_count) && $stable(nominal_count))
  `ASSERT_NEXT(a_peak_lamp, clk, rst, adv && peak_hit && (cfg.peak_hold != '0),
               m_tvalid && m_tdata[LEVEL_W])
  `ASSERT_NEXT(a_nom_lamp, clk, rst, adv && !nom_hit && (nominal_count > 16'd1),
               m_tvalid && m_tdata[LEVEL_W+1])

endmodule

### bench/testbench.sv
// Self-checking bench for dc_block_peak_hold_meter: sample stream in, filtered level and lamps out.
// Depends on dcbphm_pkg and the meter RTL; predicts every output word and compares it as it leaves.
`timescale 1ns / 1ps

module testbench;
  import dcbphm_pkg::*;

  localparam int HPF_SHIFT    = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_GAP      = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int LEVEL_MAX    = 32767;
  localparam int LEVEL_MIN    = -32768;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;
  localparam logic [ADC_W-1:0] ADC_BOTTOM = '0;
  localparam logic [ADC_W-1:0] ADC_TOP    = '1;
  localparam logic [ADC_W-1:0] ADC_MID    = 10'd512;

  typedef enum int {
    SHAPE_DC, SHAPE_SQUARE, SHAPE_RAMP, SHAPE_RAIL, SHAPE_HUM, SHAPE_NOISE
  } shape_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               peak;
    logic               nominal;
  } meter_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // predictor state
  meter_cfg_t                 meter_cfg;
  logic signed [INTEG_W-1:0]  integ_state;
  logic [HOLD_W-1:0]          peak_count;
  logic [HOLD_W-1:0]          nominal_count;
  meter_word_t                expected_words[$];

  int errors = 0;
  int samples_sent = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int settings_run = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  dc_block_peak_hold_meter #(.HPF_SHIFT(HPF_SHIFT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [HOLD_W-1:0] next_hold_count(input logic [HOLD_W-1:0] count,
      input logic [MAG_W-1:0] mag, input logic [THR_W-1:0] thr, input logic [HOLD_W-1:0] hold);
    if (mag >= thr) return hold;
    if (count != '0) return count - 1'b1;
    return '0;
  endfunction

  // Run one sample through the DC blocker and both hold detectors.
  function automatic meter_word_t filter_sample(input logic [ADC_W-1:0] adc);
    longint      x;
    longint      y;
    longint      lvl;
    logic [MAG_W-1:0] mag;
    meter_word_t w;
    x = (longint'(adc) * 64 - 32768) * 256;
    y = x - longint'(integ_state);
    integ_state = INTEG_W'(longint'(integ_state) + y / (longint'(1) << HPF_SHIFT));
    lvl = y / 256;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    if (lvl < LEVEL_MIN) lvl = LEVEL_MIN;
    if (lvl < 0) mag = (lvl == LEVEL_MIN) ? '1 : MAG_W'(-lvl);
    else mag = MAG_W'(lvl);
    peak_count = next_hold_count(peak_count, mag, meter_cfg.peak_thr, meter_cfg.peak_hold);
    nominal_count = next_hold_count(nominal_count, mag, meter_cfg.nom_thr, meter_cfg.nom_hold);
    w.level = LEVEL_W'(lvl);
    w.peak = (peak_count != '0);
    w.nominal = (nominal_count != '0);
    return w;
  endfunction

  task automatic send_sample(input logic [ADC_W-1:0] adc);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_TDATA_W-ADC_W){1'b0}}, adc};
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(filter_sample(adc));
    samples_sent++;
  endtask

  // Drop valid, let every word drain, then let the pipeline settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PEAK_THR:  meter_cfg.peak_thr = data[THR_W-1:0];
      REG_PEAK_HOLD: meter_cfg.peak_hold = data;
      REG_NOM_THR:   meter_cfg.nom_thr = data[THR_W-1:0];
      REG_NOM_HOLD:  meter_cfg.nom_hold = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Thresholds go out with a random top bit, which the block must drop.
  task automatic apply_setting(input logic [THR_W-1:0] pthr, input logic [HOLD_W-1:0] phold,
      input logic [THR_W-1:0] nthr, input logic [HOLD_W-1:0] nhold);
    wait_idle();
    write_reg(REG_PEAK_THR, {1'($urandom_range(0, 1)), pthr});
    write_reg(REG_PEAK_HOLD, phold);
    write_reg(REG_NOM_THR, {1'($urandom_range(0, 1)), nthr});
    write_reg(REG_NOM_HOLD, nhold);
    settings_run++;
  endtask

  task automatic play_waveform(input int count);
    int     left;
    int     len;
    int     k;
    int     center;
    int     period;
    int     lo;
    int     hi;
    int     v;
    shape_t shape;
    left = count;
    while (left > 0) begin
      shape = shape_t'($urandom_range(0, 5));
      len = $urandom_range(4, 40);
      if (len > left) len = left;
      no_idle = ($urandom_range(0, 3) == 0);
      center = $urandom_range(0, 1023);
      period = $urandom_range(2, 16);
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
      for (k = 0; k < len; k++) begin
        case (shape)
          SHAPE_DC:     v = center;
          SHAPE_SQUARE: v = ((k / period) % 2) ? hi : lo;
          SHAPE_RAMP:   v = (lo + k * period * 8) % 1024;
          SHAPE_RAIL:   v = (k % 2) ? int'(ADC_TOP) : int'(ADC_BOTTOM);
          SHAPE_HUM: begin
            v = center + int'($urandom_range(0, 32)) - 16;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
          end
          default:      v = $urandom_range(0, 1023);
        endcase
        send_sample(ADC_W'(v));
      end
      left -= len;
    end
    no_idle = 1'b0;
  endtask

  // Rails, midscale, bit patterns and both saturation directions at reset settings.
  task automatic test_directed_samples();
    logic [ADC_W-1:0] seq[$];
    seq = '{ADC_MID, ADC_MID, 10'd514, ADC_BOTTOM, ADC_TOP, ADC_TOP, ADC_BOTTOM,
            ADC_BOTTOM, ADC_TOP, ADC_BOTTOM, 10'd511, 10'd513, 10'h155, 10'h2AA,
            ADC_TOP, ADC_MID, 10'd768, 10'd256};
    foreach (seq[i]) send_sample(seq[i]);
    wait_idle();
  endtask

  // Unused indexes, an oversized threshold, zero threshold with zero hold, a short hold.
  task automatic test_register_corners();
    write_reg(REG_NOM_THR, 16'hFFFF);
    write_reg(REG_UNUSED_LO, 16'h0000);
    write_reg(REG_UNUSED_HI, 16'h0001);
    write_reg(REG_PEAK_THR, 16'h0000);
    write_reg(REG_PEAK_HOLD, 16'h0000);
    write_reg(REG_NOM_HOLD, 16'd2);
    send_sample(ADC_BOTTOM);
    send_sample(ADC_TOP);
    send_sample(ADC_MID);
    send_sample(ADC_MID);
    send_sample(ADC_MID);
    send_sample(10'd520);
    wait_idle();
  endtask

  task automatic test_random_settings();
    apply_setting('1, '1, '0, '1);
    play_waveform(PHASE_ITEMS);
    apply_setting('0, '0, '0, '0);
    play_waveform(PHASE_ITEMS);
    apply_setting(THR_W'($urandom_range(4000, 32767)), HOLD_W'($urandom_range(1, 40)),
                  THR_W'($urandom_range(0, 2000)), HOLD_W'($urandom_range(1, 60)));
    play_waveform(PHASE_ITEMS);
    apply_setting(THR_W'($urandom), HOLD_W'($urandom_range(0, 300)),
                  THR_W'($urandom_range(0, 4000)), HOLD_W'($urandom));
    play_waveform(PHASE_ITEMS);
    apply_setting(PEAK_THR_RST, PEAK_HOLD_RST, NOM_THR_RST, NOM_HOLD_RST);
    play_waveform(PHASE_ITEMS);
    wait_idle();
  endtask

  // Compare each word leaving the block with the oldest prediction.
  always @(posedge clk) begin : word_check
    meter_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("output word %h with no sample pending", m_tdata);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (m_tdata[LEVEL_W-1:0] !== want.level) begin
          $error("filtered_level: expected %0d, got %0d", $signed(want.level),
                 $signed(m_tdata[LEVEL_W-1:0]));
          errors++;
        end
        if (m_tdata[LEVEL_W] !== want.peak) begin
          $error("peak_lamp: expected %0b, got %0b", want.peak, m_tdata[LEVEL_W]);
          errors++;
        end
        if (m_tdata[LEVEL_W+1] !== want.nominal) begin
          $error("nominal_lamp: expected %0b, got %0b", want.nominal, m_tdata[LEVEL_W+1]);
          errors++;
        end
        if (m_tdata[M_TDATA_W-1:LEVEL_W+2] !== '0) begin
          $error("tdata padding: expected 0, got %h", m_tdata[M_TDATA_W-1:LEVEL_W+2]);
          errors++;
        end
        words_checked++;
      end
    end
  end

  // Output backpressure: a random stall, possibly none, before each word; none while no_idle is set.
  initial begin : ready_driver
    int stall;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    meter_cfg = '{peak_thr: PEAK_THR_RST, peak_hold: PEAK_HOLD_RST,
                  nom_thr: NOM_THR_RST, nom_hold: NOM_HOLD_RST};
    integ_state = '0;
    peak_count = '0;
    nominal_count = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_samples();
    test_register_corners();
    test_random_settings();
    wait_idle();
    $display("Sent %0d samples, checked %0d output words, %0d errors.",
             samples_sent, words_checked, errors);
    $display("Register writes: %0d over %0d meter settings.", reg_writes, settings_run);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dcbphm_pkg.sv
rtl/dc_block_peak_hold_meter.sv
bench/testbench.sv
